>>> rtl/ffra_pkg.sv
// Shared types and constants of the first-fit region allocator.
// No dependencies.
package ffra_pkg;

	localparam int ADDR_BITS        = 32;
	localparam int PAGE_CNT_BITS    = 21;
	localparam int DEF_MAX_REGIONS  = 512;
	localparam int DEF_PAGE_BYTES   = 4096;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_NOSPACE  = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic CFG_POOL_BASE  = 1'b0;
	localparam logic CFG_POOL_BYTES = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLAG,
		S_PREFIX,
		S_SELECT,
		S_REDUCE,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic take_new;
		logic take_left;
		logic take_right;
	} cell_ctrl_t;

endpackage

>>> rtl/ffra_cell.sv
// One entry of the region table: holds start and length, shifts with its neighbors.
// Depends on ffra_pkg.
module ffra_cell import ffra_pkg::*; (
	input  logic                  clk,
	input  cell_ctrl_t            ctl,
	input  logic                  is_first,
	input  logic                  active,
	input  logic                  op_alloc,
	input  logic [ADDR_BITS:0]    req_len,
	input  logic [ADDR_BITS-1:0]  addr,
	input  logic [ADDR_BITS-1:0]  new_start,
	input  logic [ADDR_BITS-1:0]  new_len,
	input  logic [ADDR_BITS-1:0]  left_start,
	input  logic [ADDR_BITS-1:0]  left_len,
	input  logic [ADDR_BITS-1:0]  right_start,
	input  logic [ADDR_BITS-1:0]  right_len,
	output logic [ADDR_BITS-1:0]  start_q,
	output logic [ADDR_BITS-1:0]  len_q,
	output logic                  flag,
	output logic [2*ADDR_BITS-1:0] sel_val
);

	logic [ADDR_BITS-1:0] left_end;
	logic [ADDR_BITS-1:0] gap;

	assign left_end = left_start + left_len;
	assign gap      = start_q - left_end;

	always_comb begin
		if (op_alloc) begin
			flag    = active && !is_first && ({1'b0, gap} >= req_len);
			sel_val = {{ADDR_BITS{1'b0}}, left_end};
		end else begin
			flag    = active && (start_q == addr);
			sel_val = {start_q, len_q};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_new) begin
			start_q <= new_start;
			len_q   <= new_len;
		end else if (ctl.take_left) begin
			start_q <= left_start;
			len_q   <= left_len;
		end else if (ctl.take_right) begin
			start_q <= right_start;
			len_q   <= right_len;
		end
	end

endmodule

>>> rtl/first_fit_region_allocator_unit.sv
// First-fit region allocator: top level with the cell chain and its sequencer.
// Depends on ffra_pkg and ffra_cell.
//
// Usage: a request beat is taken when start is high and busy is low. The
// config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// pool_base (index 0) and pool_bytes (index 1); cfg_ready is always high.
// Each result shows on the result ports for one cycle with done high.
// Check, unused op, zero size, table full and the first allocate into an
// empty table answer in the cycle after the beat. Other allocates and all
// releases pass through a flag state in which every cell flags its gap or
// base match, prefix OR steps that find the first flag, a select state,
// a registered OR tree that pulls out the chosen cell's data, and a commit
// state in which the chain shifts one place and the result is driven.
// Busy stays high over that span. The receiver cannot stall: done is a
// strobe. Reset empties the table (count zero) and clears the pool
// registers; entry contents are not cleared.
module first_fit_region_allocator_unit import ffra_pkg::*; #(
	parameter int MAX_REGIONS = DEF_MAX_REGIONS,
	parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               operation,
	input  logic [ADDR_BITS-1:0]     request_bytes,
	input  logic [ADDR_BITS-1:0]     address,
	output logic                     done,
	output logic [ADDR_BITS-1:0]     region_address,
	output logic [PAGE_CNT_BITS-1:0] page_count,
	output logic [1:0]               status,
	output logic                     legitimate,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [ADDR_BITS-1:0]     cfg_data
);

	localparam int LOG    = $clog2(MAX_REGIONS);
	localparam int NP     = 1 << LOG;
	localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
	localparam int STEP_W = $clog2(LOG + 1);
	localparam int PB_LOG = $clog2(PAGE_BYTES);
	localparam int DW     = 2 * ADDR_BITS;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       count_q;
	logic [ADDR_BITS-1:0]   pool_base_q, pool_bytes_q;
	logic                   op_alloc_q;
	logic [ADDR_BITS:0]     len_q;
	logic [PAGE_CNT_BITS-1:0] pages_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [STEP_W-1:0]      step_q;
	logic [NP-1:0]          pre_q, pre_d;
	logic [MAX_REGIONS-1:0] sel_q, sel_d;
	logic                   fit_q;
	logic [DW-1:0]          red_q [NP];

	logic [ADDR_BITS-1:0]   c_start [MAX_REGIONS];
	logic [ADDR_BITS-1:0]   c_len   [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] c_flag;
	logic [DW-1:0]          c_val   [MAX_REGIONS];
	cell_ctrl_t             c_ctl   [MAX_REGIONS];

	logic [ADDR_BITS:0]     req_pages;
	logic [ADDR_BITS:0]     req_len;
	logic [ADDR_BITS-1:0]   new_start, new_len;
	logic                   emit;
	logic [ADDR_BITS-1:0]   res_addr;
	logic [PAGE_CNT_BITS-1:0] res_pages;
	logic [1:0]             res_status;
	logic                   res_legit;
	logic                   cnt_inc, cnt_dec;
	logic                   do_alloc, do_release, do_first;
	logic [ADDR_BITS-1:0]   pool_top, room, base_red;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign req_pages = ({1'b0, request_bytes - 1'b1} >> PB_LOG) + 1'b1;
	assign req_len   = req_pages << PB_LOG;
	assign pool_top  = pool_base_q + pool_bytes_q;
	assign base_red  = red_q[0][ADDR_BITS-1:0];
	assign room      = pool_top - base_red;

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		logic [ADDR_BITS-1:0] ls, ll, rs, rl;
		if (i == 0) begin : g_l0
			assign ls = '0;
			assign ll = '0;
		end else begin : g_l
			assign ls = c_start[i-1];
			assign ll = c_len[i-1];
		end
		if (i == MAX_REGIONS - 1) begin : g_rn
			assign rs = '0;
			assign rl = '0;
		end else begin : g_r
			assign rs = c_start[i+1];
			assign rl = c_len[i+1];
		end
		ffra_cell u_cell (
			.clk        (clk),
			.ctl        (c_ctl[i]),
			.is_first   (i == 0),
			.active     (CNT_W'(i) < count_q),
			.op_alloc   (op_alloc_q),
			.req_len    (len_q),
			.addr       (addr_q),
			.new_start  (new_start),
			.new_len    (new_len),
			.left_start (ls),
			.left_len   (ll),
			.right_start(rs),
			.right_len  (rl),
			.start_q    (c_start[i]),
			.len_q      (c_len[i]),
			.flag       (c_flag[i]),
			.sel_val    (c_val[i])
		);
	end

	always_comb begin
		pre_d = pre_q;
		for (int i = 0; i < NP; i++) begin
			if (i >= (1 << step_q)) pre_d[i] = pre_q[i] | pre_q[i - (1 << step_q)];
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			if (pre_q[NP-1]) begin
				sel_d[i] = pre_q[i] & ((i == 0) ? 1'b1 : !pre_q[(i == 0) ? 0 : i-1]);
			end else begin
				sel_d[i] = op_alloc_q && (CNT_W'(i) == count_q);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		res_addr   = '0;
		res_pages  = '0;
		res_status = STAT_DONE;
		res_legit  = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		do_alloc   = 1'b0;
		do_release = 1'b0;
		do_first   = 1'b0;
		new_start  = base_red;
		new_len    = len_q[ADDR_BITS-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op_t'(operation))
						OP_ALLOC: begin
							if (request_bytes == '0) begin
								emit       = 1'b1;
								res_status = STAT_NOSPACE;
							end else if (count_q >= CNT_W'(MAX_REGIONS)) begin
								emit       = 1'b1;
								res_status = STAT_FULL;
							end else if (count_q == '0) begin
								emit      = 1'b1;
								do_first  = 1'b1;
								cnt_inc   = 1'b1;
								new_start = pool_base_q + ADDR_BITS'(PAGE_BYTES);
								new_len   = req_len[ADDR_BITS-1:0];
								res_addr  = new_start;
								res_pages = req_pages[PAGE_CNT_BITS-1:0];
							end else begin
								state_d = S_FLAG;
							end
						end
						OP_RELEASE: state_d = S_FLAG;
						OP_CHECK: begin
							emit      = 1'b1;
							res_legit = (address >= pool_base_q) && (address < pool_top);
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_FLAG:   state_d = S_PREFIX;
			S_PREFIX: if (step_q == STEP_W'(LOG - 1)) state_d = S_SELECT;
			S_SELECT: state_d = S_REDUCE;
			S_REDUCE: if (step_q == STEP_W'(LOG - 1)) state_d = S_COMMIT;
			S_COMMIT: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				if (op_alloc_q) begin
					if (!fit_q && ({1'b0, room} < len_q)) begin
						res_status = STAT_NOSPACE;
					end else begin
						do_alloc  = 1'b1;
						cnt_inc   = 1'b1;
						res_addr  = base_red;
						res_pages = pages_q;
					end
				end else if (!fit_q) begin
					res_status = STAT_NOTFOUND;
				end else begin
					do_release = 1'b1;
					cnt_dec    = 1'b1;
					res_addr   = red_q[0][DW-1:ADDR_BITS];
					res_pages  = PAGE_CNT_BITS'(red_q[0][ADDR_BITS-1:0] >> PB_LOG);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_REGIONS; i++) begin
			c_ctl[i].take_new   = (do_first && i == 0) || (do_alloc && sel_q[i]);
			if (fit_q) begin
				c_ctl[i].take_left = do_alloc && (i > 0) && pre_q[(i == 0) ? 0 : i-1];
			end else begin
				c_ctl[i].take_left = do_alloc && (CNT_W'(i) > count_q);
			end
			c_ctl[i].take_right = do_release && pre_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pool_base_q  <= '0;
			pool_bytes_q <= '0;
			done         <= 1'b0;
			step_q       <= '0;
		end else begin
			state_q <= state_d;
			done    <= emit;
			if (cnt_inc) count_q <= count_q + 1'b1;
			else if (cnt_dec) count_q <= count_q - 1'b1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POOL_BASE) pool_base_q <= cfg_data;
				else pool_bytes_q <= cfg_data;
			end
			if ((state_q == S_PREFIX || state_q == S_REDUCE) && step_q != STEP_W'(LOG - 1))
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			region_address <= res_addr;
			page_count     <= res_pages;
			status         <= res_status;
			legitimate     <= res_legit;
		end
		if (state_q == S_IDLE && start) begin
			op_alloc_q <= (op_t'(operation) == OP_ALLOC);
			len_q      <= req_len;
			pages_q    <= req_pages[PAGE_CNT_BITS-1:0];
			addr_q     <= address;
		end
		case (state_q)
			S_FLAG:   pre_q <= NP'(c_flag);
			S_PREFIX: pre_q <= pre_d;
			S_SELECT: begin
				sel_q <= sel_d;
				fit_q <= pre_q[NP-1];
				for (int i = 0; i < NP; i++) begin
					if (i < MAX_REGIONS && sel_d[(i < MAX_REGIONS) ? i : 0])
						red_q[i] <= c_val[(i < MAX_REGIONS) ? i : 0];
					else
						red_q[i] <= '0;
				end
			end
			S_REDUCE: begin
				for (int i = 0; i < NP / 2; i++) red_q[i] <= red_q[2*i] | red_q[2*i+1];
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/ffra_checker.sv
// Port-level checks of the first-fit region allocator, bound to its top level.
// Depends on ffra_pkg and first_fit_region_allocator_unit.
module ffra_checker import ffra_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic [ADDR_BITS-1:0]     region_address,
	input logic [PAGE_CNT_BITS-1:0] page_count,
	input logic [1:0]               status,
	input logic                     legitimate
);

	a_answer_or_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("beat neither answered nor in progress");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_DONE) |-> (region_address == '0 && page_count == '0))
		else $error("failed result carries data");

	a_legit_check: assert property (@(posedge clk) disable iff (!arst_n)
		(done && legitimate) |-> (status == STAT_DONE && region_address == '0))
		else $error("legitimate flag on non-check result");

endmodule

bind first_fit_region_allocator_unit ffra_checker u_ffra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.region_address(region_address),
	.page_count    (page_count),
	.status        (status),
	.legitimate    (legitimate)
);
